/* rtl/tsfe_pkg.sv */
`timescale 1ns / 1ps
package tsfe_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_TYPE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGULAR_FREQ = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHELL_HALF = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOX_HALF = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ORIGIN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_STEP = 3'd6;

  localparam logic [3:0] SURF_P = 4'd0;
  localparam logic [3:0] SURF_D = 4'd1;
  localparam logic [3:0] SURF_G = 4'd2;
  localparam logic [3:0] SURF_L = 4'd3;
  localparam logic [3:0] SURF_IWP = 4'd4;
  localparam logic [3:0] SURF_TUB_P = 4'd5;
  localparam logic [3:0] SURF_TUB_G = 4'd6;
  localparam logic [3:0] SURF_FRD = 4'd7;
  localparam logic [3:0] SURF_PW = 4'd8;
  localparam logic [3:0] SURF_N = 4'd9;
  localparam logic [3:0] SURF_SD = 4'd10;
  localparam logic [3:0] SURF_SPHERE = 4'd11;

  localparam logic [3:0] SURFACE_TYPE_RST = SURF_G;
  localparam logic [19:0] ANGULAR_FREQ_RST = 20'd12353;
  localparam logic [19:0] SHELL_HALF_RST = 20'd11796;
  localparam logic signed [20:0] LEVEL_OFFSET_RST = 21'sd0;
  localparam logic [22:0] BOX_HALF_RST = 23'd3276800;
  localparam logic signed [23:0] GRID_ORIGIN_RST = -24'sd3283354;
  localparam logic [19:0] GRID_STEP_RST = 20'd66330;

  localparam logic [29:0] TURNS_K = 30'd683565276;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int SPH_W = 36;
  localparam int PER_W = 32;
  localparam int FIELD_W = 30;

  localparam logic signed [SPH_W-1:0] SPHERE_R2 = 36'sd163840000;
  localparam logic signed [SPH_W-1:0] FAR_VALUE = 36'sd65536000;
  localparam logic signed [SPH_W-1:0] FIELD_MAX = 36'sd536870911;
  localparam logic signed [SPH_W-1:0] FIELD_MIN = -36'sd536870912;
  localparam logic signed [PER_W-1:0] L_CONST = 32'sd9830;
  localparam logic signed [PER_W-1:0] TUB_P_CONST = 32'sd956826;
  localparam logic signed [PER_W-1:0] TUB_G_CONST = 32'sd917504;
  localparam logic signed [39:0] TUB_P_GAIN = 40'sd334234;

  typedef struct packed {
    logic signed [17:0] s;
    logic signed [17:0] c;
    logic signed [17:0] s2;
    logic signed [17:0] c2;
  } trig_t;

  function automatic logic [16:0] qsin_entry(input int tb, input int j);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] acc;
    x = (64'(j) * HALF_PI_Q30) >> (tb - 2);
    term = x;
    acc = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      unique case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 64'sd0;
    acc = (acc + 64'sd8192) >>> 14;
    if (acc > 64'sd65536) acc = 64'sd65536;
    return acc[16:0];
  endfunction

endpackage

/* rtl/tpms_shell_field_eval.sv */
`timescale 1ns / 1ps
// Shell field evaluator for triply periodic minimal surfaces and a sphere. It takes one voxel
// a cycle while the output is not stalled and returns its field value from nine register
// stages, owned by coordinate, angle, phase products, phase index, table sine, two product
// levels, the surface formula and the shell with saturation in turn. Every stage holds a
// valid bit and takes a new beat whenever it is empty or its successor moves, so a stalled
// output only stops the stages that are full and one voxel per clock is sustained. Registers
// must only be written while no beat is in flight.
module tpms_shell_field_eval #(
  parameter int INDEX_WIDTH = 8,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [INDEX_WIDTH-1:0]              in_x_index,
  input  logic [INDEX_WIDTH-1:0]              in_y_index,
  input  logic [INDEX_WIDTH-1:0]              in_z_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tsfe_pkg::FIELD_W-1:0] out_field_value,
  output logic                                out_solid,
  output logic                                out_outside_box,
  input  logic                                cfg_we,
  input  logic [tsfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tsfe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tsfe_pkg::*;

  localparam int CW = INDEX_WIDTH + 26;
  localparam int TW = CW + 5;
  localparam int NS = 9;

  logic [3:0] surface_type_r;
  logic [19:0] angular_freq_r, shell_half_r, grid_step_r;
  logic signed [20:0] level_offset_r;
  logic [22:0] box_half_r;
  logic signed [23:0] grid_origin_r;

  logic [NS-1:0] vld_r, vld_nxt, en;
  logic signed [TW-1:0] t_s1 [3];
  trig_t trig_s4 [3];
  logic signed [SPH_W-1:0] sph_s1;
  logic outside_s1;
  logic signed [SPH_W-1:0] sph_r [2:7];
  logic outside_r [2:7];
  logic signed [PER_W-1:0] v_s7;
  logic signed [FIELD_W-1:0] field_r, field_nxt;
  logic outside_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_type_r <= SURFACE_TYPE_RST;
      angular_freq_r <= ANGULAR_FREQ_RST;
      shell_half_r <= SHELL_HALF_RST;
      level_offset_r <= LEVEL_OFFSET_RST;
      box_half_r <= BOX_HALF_RST;
      grid_origin_r <= GRID_ORIGIN_RST;
      grid_step_r <= GRID_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SURFACE_TYPE: surface_type_r <= cfg_wdata[3:0];
        CFG_ANGULAR_FREQ: angular_freq_r <= cfg_wdata[19:0];
        CFG_SHELL_HALF: shell_half_r <= cfg_wdata[19:0];
        CFG_LEVEL_OFFSET: level_offset_r <= cfg_wdata[20:0];
        CFG_BOX_HALF: box_half_r <= cfg_wdata[22:0];
        CFG_GRID_ORIGIN: grid_origin_r <= cfg_wdata[23:0];
        CFG_GRID_STEP: grid_step_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !en[0];

  tsfe_coord #(.IW(INDEX_WIDTH), .CW(CW), .TW(TW)) u_coord (
    .clk             (clk),
    .en              (en[1:0]),
    .x_index         (in_x_index),
    .y_index         (in_y_index),
    .z_index         (in_z_index),
    .grid_origin     (grid_origin_r),
    .grid_step       (grid_step_r),
    .angular_freq    (angular_freq_r),
    .box_half_extent (box_half_r),
    .t_out           (t_s1),
    .sph_out         (sph_s1),
    .outside_out     (outside_s1)
  );

  tsfe_trig #(.TW(TW), .TB(TRIG_TABLE_BITS)) u_trig (
    .clk      (clk),
    .en       (en[4:2]),
    .t_in     (t_s1),
    .trig_out (trig_s4)
  );

  tsfe_surf u_surf (
    .clk          (clk),
    .en           (en[7:5]),
    .trig_in      (trig_s4),
    .surface_type (surface_type_r),
    .level_offset (level_offset_r),
    .v_out        (v_s7)
  );

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sph_r[2] <= sph_s1;
      outside_r[2] <= outside_s1;
    end
    for (int k = 3; k <= 7; k++) begin
      if (en[k]) begin
        sph_r[k] <= sph_r[k-1];
        outside_r[k] <= outside_r[k-1];
      end
    end
  end

  always_comb begin
    logic signed [SPH_W-1:0] v, res;
    v = SPH_W'(v_s7);
    if (outside_r[7]) begin
      res = FAR_VALUE;
    end else if (surface_type_r == SURF_SPHERE) begin
      res = sph_r[7];
    end else if (v > 0) begin
      res = v - SPH_W'(shell_half_r);
    end else if (v < 0) begin
      res = -v - SPH_W'(shell_half_r);
    end else begin
      res = '0;
    end
    if (res > FIELD_MAX) res = FIELD_MAX;
    if (res < FIELD_MIN) res = FIELD_MIN;
    field_nxt = res[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      field_r <= field_nxt;
      outside_out_r <= outside_r[7];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_field_value = field_r;
  assign out_solid = field_r[FIELD_W-1];
  assign out_outside_box = outside_out_r;

  a_outside_far: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside_box |-> out_field_value == FIELD_W'(FAR_VALUE))
    else $error("Beat outside the cube without the far value.");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NS-1] |-> !in_stall)
    else $error("Input stalled while the output stage is empty.");

  a_moves_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && !in_stall |=> vld_r[1])
    else $error("Beat lost between the first two stages.");

endmodule

/* rtl/tsfe_coord.sv */
`timescale 1ns / 1ps
module tsfe_coord #(
  parameter int IW = 8,
  parameter int CW = 34,
  parameter int TW = 39
) (
  input  logic                         clk,
  input  logic [1:0]                   en,
  input  logic [IW-1:0]                x_index,
  input  logic [IW-1:0]                y_index,
  input  logic [IW-1:0]                z_index,
  input  logic signed [23:0]           grid_origin,
  input  logic [19:0]                  grid_step,
  input  logic [19:0]                  angular_freq,
  input  logic [22:0]                  box_half_extent,
  output logic signed [TW-1:0]         t_out [3],
  output logic signed [tsfe_pkg::SPH_W-1:0] sph_out,
  output logic                         outside_out
);
  import tsfe_pkg::*;

  logic signed [CW-1:0] c_r [3];
  logic signed [CW-1:0] c_nxt [3];
  logic [IW-1:0] idx [3];
  logic signed [TW-1:0] t_r [3];
  logic signed [TW-1:0] t_nxt [3];
  logic signed [SPH_W-1:0] sph_r, sph_nxt;
  logic outside_r, outside_nxt;

  assign idx[0] = x_index;
  assign idx[1] = y_index;
  assign idx[2] = z_index;

  always_comb begin
    logic [IW+19:0] prod;
    for (int a = 0; a < 3; a++) begin
      prod = (IW + 20)'(idx[a]) * (IW + 20)'(grid_step);
      c_nxt[a] = CW'(grid_origin) + CW'($signed({1'b0, prod}));
    end
  end

  always_comb begin
    logic signed [CW+20:0] tm;
    logic signed [23:0] ck;
    logic signed [47:0] sq;
    logic [CW-1:0] mag;
    logic signed [SPH_W-1:0] acc;
    outside_nxt = 1'b0;
    acc = SPHERE_R2;
    for (int a = 0; a < 3; a++) begin
      tm = (CW + 21)'(c_r[a]) * (CW + 21)'($signed({1'b0, angular_freq}));
      t_nxt[a] = tm[CW+20:16];
      mag = c_r[a][CW-1] ? CW'(-c_r[a]) : CW'(c_r[a]);
      if (mag > CW'(box_half_extent)) outside_nxt = 1'b1;
      ck = c_r[a][23:0];
      sq = ck * ck;
      acc = acc - SPH_W'($signed({1'b0, sq[47:16]}));
    end
    sph_nxt = acc;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c_r <= c_nxt;
    end
    if (en[1]) begin
      t_r <= t_nxt;
      sph_r <= sph_nxt;
      outside_r <= outside_nxt;
    end
  end

  assign t_out = t_r;
  assign sph_out = sph_r;
  assign outside_out = outside_r;

endmodule

/* rtl/tsfe_trig.sv */
`timescale 1ns / 1ps
module tsfe_trig #(
  parameter int TW = 39,
  parameter int TB = 10
) (
  input  logic                  clk,
  input  logic [2:0]            en,
  input  logic signed [TW-1:0]  t_in [3],
  output tsfe_pkg::trig_t       trig_out [3]
);
  import tsfe_pkg::*;

  localparam int Q = 1 << (TB - 2);

  logic [16:0] qtab [0:Q];
  logic [47:0] pl_r [3];
  logic [47:0] pl_nxt [3];
  logic [23:0] ph_r [3];
  logic [23:0] ph_nxt [3];
  logic [TB-1:0] i1_r [3];
  logic [TB-1:0] i1_nxt [3];
  logic [TB-1:0] i2_r [3];
  logic [TB-1:0] i2_nxt [3];
  trig_t trig_r [3];
  trig_t trig_nxt [3];

  for (genvar j = 0; j <= Q; j++) begin : g_tab
    assign qtab[j] = qsin_entry(TB, j);
  end

  function automatic logic signed [17:0] tsin(input logic [TB-1:0] i);
    logic [TB-2:0] r;
    logic [TB-2:0] sel;
    logic signed [17:0] mag;
    r = {1'b0, i[TB-3:0]};
    sel = i[TB-2] ? ((TB - 1)'(Q) - r) : r;
    mag = $signed({1'b0, qtab[sel]});
    return i[TB-1] ? -mag : mag;
  endfunction

  always_comb begin
    logic signed [47:0] t48;
    logic [53:0] lo;
    logic [47:0] sum;
    for (int a = 0; a < 3; a++) begin
      t48 = 48'(t_in[a]);
      lo = 54'(t48[23:0]) * 54'(TURNS_K);
      pl_nxt[a] = lo[47:0];
      ph_nxt[a] = t48[47:24] * TURNS_K[23:0];
      sum = pl_r[a] + {ph_r[a], 24'b0};
      i1_nxt[a] = sum[47 -: TB];
      i2_nxt[a] = sum[46 -: TB];
      trig_nxt[a].s = tsin(i1_r[a]);
      trig_nxt[a].c = tsin(i1_r[a] + TB'(Q));
      trig_nxt[a].s2 = tsin(i2_r[a]);
      trig_nxt[a].c2 = tsin(i2_r[a] + TB'(Q));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (en[1]) begin
      i1_r <= i1_nxt;
      i2_r <= i2_nxt;
    end
    if (en[2]) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig_out = trig_r;

endmodule

/* rtl/tsfe_surf.sv */
`timescale 1ns / 1ps
module tsfe_surf (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  tsfe_pkg::trig_t                   trig_in [3],
  input  logic [3:0]                        surface_type,
  input  logic signed [20:0]                level_offset,
  output logic signed [tsfe_pkg::PER_W-1:0] v_out
);
  import tsfe_pkg::*;

  function automatic logic signed [17:0] m2(input logic signed [17:0] a,
                                            input logic signed [17:0] b);
    logic signed [35:0] p;
    p = a * b;
    return p[33:16];
  endfunction

  trig_t tr_r [3];
  logic signed [17:0] xcyc_r, ycz_c_r, zcxc_r, xc2yc2_r, yc2zc2_r, zc2xc2_r;
  logic signed [17:0] xsyc_r, yszc_r, zsxc_r, xcys_r, yczs_r, zcxs_r;
  logic signed [17:0] xsys_r, xs2yc_r, ys2zc_r, zs2xc_r;
  logic signed [17:0] c3_r, s3_r, l1_r, l2_r, l3_r, sd1_r, sd2_r, sd3_r;
  logic signed [19:0] cc_r, cc2_r, csum_r, c2sum_r, gsum_r, tgsum_r;
  logic signed [PER_W-1:0] v_r, v_nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tr_r <= trig_in;
      xcyc_r <= m2(trig_in[0].c, trig_in[1].c);
      ycz_c_r <= m2(trig_in[1].c, trig_in[2].c);
      zcxc_r <= m2(trig_in[2].c, trig_in[0].c);
      xc2yc2_r <= m2(trig_in[0].c2, trig_in[1].c2);
      yc2zc2_r <= m2(trig_in[1].c2, trig_in[2].c2);
      zc2xc2_r <= m2(trig_in[2].c2, trig_in[0].c2);
      xsyc_r <= m2(trig_in[0].s, trig_in[1].c);
      yszc_r <= m2(trig_in[1].s, trig_in[2].c);
      zsxc_r <= m2(trig_in[2].s, trig_in[0].c);
      xcys_r <= m2(trig_in[0].c, trig_in[1].s);
      yczs_r <= m2(trig_in[1].c, trig_in[2].s);
      zcxs_r <= m2(trig_in[2].c, trig_in[0].s);
      xsys_r <= m2(trig_in[0].s, trig_in[1].s);
      xs2yc_r <= m2(trig_in[0].s2, trig_in[1].c);
      ys2zc_r <= m2(trig_in[1].s2, trig_in[2].c);
      zs2xc_r <= m2(trig_in[2].s2, trig_in[0].c);
    end
    if (en[1]) begin
      c3_r <= m2(xcyc_r, tr_r[2].c);
      s3_r <= m2(xsys_r, tr_r[2].s);
      l1_r <= m2(xs2yc_r, tr_r[2].s);
      l2_r <= m2(ys2zc_r, tr_r[0].s);
      l3_r <= m2(zs2xc_r, tr_r[1].s);
      sd1_r <= m2(xsyc_r, tr_r[2].c);
      sd2_r <= m2(xcys_r, tr_r[2].c);
      sd3_r <= m2(xcyc_r, tr_r[2].s);
      cc_r <= 20'(xcyc_r) + 20'(ycz_c_r) + 20'(zcxc_r);
      cc2_r <= 20'(xc2yc2_r) + 20'(yc2zc2_r) + 20'(zc2xc2_r);
      csum_r <= 20'(tr_r[0].c) + 20'(tr_r[1].c) + 20'(tr_r[2].c);
      c2sum_r <= 20'(tr_r[0].c2) + 20'(tr_r[1].c2) + 20'(tr_r[2].c2);
      gsum_r <= 20'(xsyc_r) + 20'(yszc_r) + 20'(zsxc_r);
      tgsum_r <= 20'(xcys_r) + 20'(yczs_r) + 20'(zcxs_r);
    end
    if (en[2]) begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    logic signed [PER_W-1:0] lo, cc, cc2, csum, c3, lsum, sds;
    logic signed [39:0] tp;
    lo = PER_W'(level_offset);
    cc = PER_W'(cc_r);
    cc2 = PER_W'(cc2_r);
    csum = PER_W'(csum_r);
    c3 = PER_W'(c3_r);
    lsum = PER_W'(l1_r) + PER_W'(l2_r) + PER_W'(l3_r);
    sds = PER_W'(s3_r) + PER_W'(sd1_r) + PER_W'(sd2_r) + PER_W'(sd3_r);
    tp = 40'(cc_r) * TUB_P_GAIN;
    unique case (surface_type)
      SURF_P: v_nxt = csum + lo;
      SURF_D: v_nxt = c3 - PER_W'(s3_r) + lo;
      SURF_G: v_nxt = PER_W'(gsum_r) + lo;
      SURF_L: v_nxt = (lsum >>> 1) - (cc2 >>> 1) + L_CONST;
      SURF_IWP: v_nxt = 2 * cc - PER_W'(c2sum_r) + lo;
      SURF_TUB_P: v_nxt = 10 * csum - PER_W'(tp >>> 16) - TUB_P_CONST;
      SURF_TUB_G: v_nxt = 10 * PER_W'(tgsum_r) - (cc2 >>> 1) - TUB_G_CONST;
      SURF_FRD: v_nxt = 4 * c3 - cc2 + lo;
      SURF_PW: v_nxt = 4 * cc - 3 * c3 + lo;
      SURF_N: v_nxt = 3 * csum + 4 * c3 + lo;
      SURF_SD: v_nxt = sds;
      default: v_nxt = '0;
    endcase
  end

  assign v_out = v_r;

endmodule
